### rtl/ecd_pkg.sv
// Package for the epoch-seconds to civil-date converter.
// Holds pipeline depth, calendar constants, reciprocal multipliers and the month table.
// Used by ecd_dp and epoch_seconds_to_civil_date.
package ecd_pkg;

    localparam int NSTG = 14;

    localparam int SEC_W = 48;
    localparam int YEAR_W = 24;
    localparam int MONTH_W = 4;
    localparam int DAY_W = 5;
    localparam int WDAY_W = 3;
    localparam int OUT_TDATA_W = 40;

    localparam longint SECONDS_PER_DAY = 86400;
    localparam longint DAYS_PER_ERA_L = 146097;
    localparam longint DAYS_TO_MARCH_EPOCH = 719468;
    localparam longint ERA_BIAS = 11150;
    localparam longint DAY_BIAS = DAYS_TO_MARCH_EPOCH + ERA_BIAS * DAYS_PER_ERA_L;

    localparam logic [48:0] SEC_OFFSET = 49'(DAY_BIAS * SECONDS_PER_DAY);
    localparam logic [23:0] YEAR_BIAS = 24'(ERA_BIAS * 400);

    localparam logic [9:0]  DIV675 = 10'd675;
    localparam logic [17:0] DAYS_PER_ERA = 18'(DAYS_PER_ERA_L);
    localparam logic [17:0] LAST_DOE = 18'd146096;
    localparam logic [17:0] DAYS_PER_YEAR = 18'd365;

    localparam logic [21:0] M675A  = 22'(((longint'(1) << 31) + 674) / 675);
    localparam logic [31:0] M675B  = 32'(((longint'(1) << 41) + 674) / 675);
    localparam logic [14:0] MERA   = 15'((longint'(1) << 32) / DAYS_PER_ERA_L);
    localparam logic [18:0] M1460  = 19'(((longint'(1) << 29) + 1459) / 1460);
    localparam logic [18:0] M36524 = 19'(((longint'(1) << 34) + 36523) / 36524);
    localparam logic [18:0] M365   = 19'(((longint'(1) << 27) + 364) / 365);
    localparam logic [9:0]  M100   = 10'(((longint'(1) << 16) + 99) / 100);
    localparam logic [11:0] M153   = 12'(((longint'(1) << 19) + 152) / 153);

    typedef logic [NSTG-1:0] stage_vec_t;

    // First day of each shifted month, March first, counted within the March-based year.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] s;
        case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

### rtl/ecd_dp.sv
// Datapath of the epoch-seconds to civil-date converter: fourteen register stages.
// Each stage loads when its bit of the enable vector is set; depends on ecd_pkg.
module ecd_dp (
    input  logic                        clk,
    input  ecd_pkg::stage_vec_t         en,
    input  logic [ecd_pkg::SEC_W-1:0]   local_seconds,
    output logic [ecd_pkg::YEAR_W-1:0]  year,
    output logic [ecd_pkg::MONTH_W-1:0] month,
    output logic [ecd_pkg::DAY_W-1:0]   day_of_month,
    output logic [ecd_pkg::WDAY_W-1:0]  weekday
);
    import ecd_pkg::*;

    logic [41:0] v0_reg;
    logic [20:0] a1_reg, b1_reg;
    logic [11:0] qa1_reg, qa2_reg;
    logic [30:0] r2_reg;
    logic [31:0] z3_reg, z4_reg;
    logic [14:0] era4_reg, era5_reg, era6_reg, era7_reg, era8_reg, era9_reg;
    logic [14:0] era10_reg, era11_reg, era12_reg;
    logic [6:0]  ws4_reg;
    logic [18:0] r5_reg;
    logic [2:0]  wd5_reg, wd6_reg, wd7_reg, wd8_reg, wd9_reg, wd10_reg, wd11_reg, wd12_reg;
    logic [17:0] doe6_reg, doe7_reg, doe8_reg, doe9_reg, doe10_reg;
    logic [6:0]  t1_7_reg;
    logic [2:0]  t2_7_reg;
    logic        t3_7_reg;
    logic [17:0] yn8_reg;
    logic [8:0]  yoe9_reg, yoe10_reg, yoe11_reg, yoe12_reg;
    logic [17:0] base10_reg;
    logic [2:0]  c100_10_reg;
    logic [8:0]  doy11_reg, doy12_reg;
    logic [3:0]  mp12_reg;
    logic [23:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [2:0]  wd_reg;

    logic [48:0] u_next;
    logic [21:0] qm;
    logic [9:0]  ra;
    logic [62:0] pb;
    logic [46:0] pe;
    logic [32:0] zw;
    logic [6:0]  ws_next;
    logic [3:0]  w1;
    logic [3:0]  w2;
    logic [2:0]  wd5_next;
    logic [31:0] pm;
    logic        wrap;
    logic [36:0] p1460, p36524, p365;
    logic [18:0] p100;
    logic [10:0] x153;
    logic [22:0] p153;
    logic [3:0]  mm;
    logic [23:0] year_next;

    assign u_next = {{1{local_seconds[SEC_W-1]}}, local_seconds} + SEC_OFFSET;
    assign qm     = 22'(qa1_reg) * 22'(DIV675);
    assign ra     = 10'(a1_reg - qm[20:0]);
    assign pb     = 63'(r2_reg) * 63'(M675B);
    assign pe     = 47'(z3_reg) * 47'(MERA);
    assign zw     = 33'(z3_reg) + 33'd3;

    // Weekday is (z + 3) mod 7 with z the biased day number; 8 is 1 modulo 7.
    always_comb
    begin
        ws_next = '0;
        for (int i = 0; i < 11; i++)
        begin
            ws_next = ws_next + 7'(zw[3*i +: 3]);
        end
    end

    always_comb
    begin
        w1 = 4'(ws4_reg[2:0]) + 4'(ws4_reg[5:3]) + 4'(ws4_reg[6]);
        w2 = 4'(w1[2:0]) + 4'(w1[3]);
        wd5_next = (w2 >= 4'd7) ? 3'(w2 - 4'd7) : w2[2:0];
    end

    assign pm     = 32'(era4_reg) * 32'(DAYS_PER_ERA);
    assign wrap   = r5_reg >= 19'(DAYS_PER_ERA);
    assign p1460  = 37'(doe6_reg) * 37'(M1460);
    assign p36524 = 37'(doe6_reg) * 37'(M36524);
    assign p365   = 37'(yn8_reg) * 37'(M365);
    assign p100   = 19'(yoe9_reg) * 19'(M100);
    assign x153   = {doy11_reg, 2'b00} + 11'(doy11_reg) + 11'd2;
    assign p153   = 23'(x153) * 23'(M153);
    assign mm     = (mp12_reg < 4'd10) ? mp12_reg + 4'd3 : mp12_reg - 4'd9;
    assign year_next = 24'(yoe12_reg) + 24'(era12_reg) * 24'd400 - YEAR_BIAS
                       + 24'(mm <= 4'd2);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            v0_reg <= u_next[48:7];
        end
        if (en[1])
        begin
            a1_reg  <= v0_reg[41:21];
            b1_reg  <= v0_reg[20:0];
            qa1_reg <= 12'(v0_reg[41:21] * 43'(M675A) >> 31);
        end
        if (en[2])
        begin
            r2_reg  <= {ra, b1_reg};
            qa2_reg <= qa1_reg;
        end
        if (en[3])
        begin
            z3_reg <= {qa2_reg[10:0], pb[61:41]};
        end
        if (en[4])
        begin
            era4_reg <= pe[46:32];
            z4_reg   <= z3_reg;
            ws4_reg  <= ws_next;
        end
        if (en[5])
        begin
            r5_reg   <= 19'(z4_reg - pm);
            era5_reg <= era4_reg;
            wd5_reg  <= wd5_next;
        end
        if (en[6])
        begin
            era6_reg <= wrap ? era5_reg + 15'd1 : era5_reg;
            doe6_reg <= wrap ? 18'(r5_reg - 19'(DAYS_PER_ERA)) : r5_reg[17:0];
            wd6_reg  <= wd5_reg;
        end
        if (en[7])
        begin
            t1_7_reg <= p1460[35:29];
            t2_7_reg <= p36524[36:34];
            t3_7_reg <= doe6_reg == LAST_DOE;
            doe7_reg <= doe6_reg;
            era7_reg <= era6_reg;
            wd7_reg  <= wd6_reg;
        end
        if (en[8])
        begin
            yn8_reg  <= doe7_reg - 18'(t1_7_reg) + 18'(t2_7_reg) - 18'(t3_7_reg);
            doe8_reg <= doe7_reg;
            era8_reg <= era7_reg;
            wd8_reg  <= wd7_reg;
        end
        if (en[9])
        begin
            yoe9_reg <= p365[35:27];
            doe9_reg <= doe8_reg;
            era9_reg <= era8_reg;
            wd9_reg  <= wd8_reg;
        end
        if (en[10])
        begin
            base10_reg  <= 18'(yoe9_reg) * DAYS_PER_YEAR + 18'(yoe9_reg[8:2]);
            c100_10_reg <= p100[18:16];
            doe10_reg   <= doe9_reg;
            yoe10_reg   <= yoe9_reg;
            era10_reg   <= era9_reg;
            wd10_reg    <= wd9_reg;
        end
        if (en[11])
        begin
            doy11_reg <= 9'(doe10_reg - base10_reg + 18'(c100_10_reg));
            yoe11_reg <= yoe10_reg;
            era11_reg <= era10_reg;
            wd11_reg  <= wd10_reg;
        end
        if (en[12])
        begin
            mp12_reg  <= p153[22:19];
            doy12_reg <= doy11_reg;
            yoe12_reg <= yoe11_reg;
            era12_reg <= era11_reg;
            wd12_reg  <= wd11_reg;
        end
        if (en[13])
        begin
            year_reg  <= year_next;
            month_reg <= mm;
            day_reg   <= 5'(doy12_reg - month_start(mp12_reg) + 9'd1);
            wd_reg    <= wd12_reg;
        end
    end

    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = day_reg;
    assign weekday      = wd_reg;

endmodule

### rtl/epoch_seconds_to_civil_date.sv
// Top level of the epoch-seconds to civil-date converter: stream ports and pipeline control.
// Instantiates ecd_dp; depends on ecd_pkg.
//
// Each input transaction carries signed 48-bit local seconds since 1970-01-01 and yields
// exactly one output transaction with the proleptic Gregorian year, month, day and weekday.
// The block takes one transaction per cycle while m_axis_tready is high or some stage is empty;
// its pipeline depth is set by the chain of constant-reciprocal multiplies that divides by 86400, by the
// 400-year era and by the year and month lengths, each followed by its own register stage.
// A stalled output holds the pipeline only as far as it is full; empty stages still fill.
module epoch_seconds_to_civil_date (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // local_seconds[47:0]
    input  logic [ecd_pkg::SEC_W-1:0]           s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // year[23:0], month[27:24], day_of_month[32:28], weekday[35:33], zero[39:36]
    output logic [ecd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import ecd_pkg::*;

    stage_vec_t vld_reg, vld_next, en;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day_of_month;
    logic [WDAY_W-1:0]  weekday;

    // A stage may load when the output is ready or some stage at or after it is empty.
    always_comb
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            en[k] = m_axis_tready || (((~vld_reg) >> k) != '0);
        end
        vld_next[0] = en[0] ? s_axis_tvalid : vld_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    ecd_dp u_dp (
        .clk           (clk),
        .en            (en),
        .local_seconds (s_axis_tdata),
        .year          (year),
        .month         (month),
        .day_of_month  (day_of_month),
        .weekday       (weekday)
    );

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = vld_reg[NSTG-1];
    assign m_axis_tdata  = {4'b0000, weekday, day_of_month, month, year};

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&vld_reg) && !m_axis_tready)
        else $error("input blocked while the pipeline has room");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted transaction did not enter the first stage");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> month >= 4'd1 && month <= 4'd12)
        else $error("month out of range");

    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> day_of_month >= 5'd1 && weekday <= 3'd6)
        else $error("day or weekday out of range");

endmodule
